// ===== hw/rtl/zigzag_diagonal_reorder_macros.svh =====
`ifndef ZIGZAG_DIAGONAL_REORDER_MACROS_SVH
`define ZIGZAG_DIAGONAL_REORDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ZDR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zdr same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ZDR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zdr next-cycle check failed");

`endif

// ===== hw/rtl/zdr_pkg.sv =====
package zdr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 4;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PROD_W      = ROW_W + CNT_W;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } rd_req_t;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int maxv);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (int'(v) > maxv) begin
      res = CNT_W'(maxv);
    end else begin
      res = CNT_W'(v);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/zdr_ram.sv =====
module zdr_ram
  import zdr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/zdr_walk.sv =====
module zdr_walk
  import zdr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] start_rows,
  input  logic [CNT_W-1:0] start_cols,
  input  logic [CNT_W-1:0] start_total,
  input  logic             req_ok,
  output logic             busy,
  output rd_req_t          req
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cols;
  logic [CNT_W-1:0] total;

  logic [PROD_W-1:0] idx;
  logic              at_last_col;
  logic              at_last_row;
  logic              up_right;

  always_comb begin
    idx         = PROD_W'(r) * PROD_W'(cols) + PROD_W'(c);
    at_last_col = (CNT_W'(c) == cols - CNT_W'(1));
    at_last_row = (CNT_W'(r) == rows - CNT_W'(1));
    up_right    = ~(r[0] ^ c[0]);
    busy        = (state == EMIT);
    req.en      = busy && req_ok;
    req.addr    = idx[ADDR_W-1:0];
    req.last    = (k == total - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state <= EMIT;
            r     <= '0;
            c     <= '0;
            k     <= '0;
            rows  <= start_rows;
            cols  <= start_cols;
            total <= start_total;
          end
        end
        EMIT: begin
          if (req.en) begin
            k <= k + CNT_W'(1);
            if (req.last) begin
              state <= IDLE;
            end
            if (up_right) begin
              if (at_last_col) begin
                r <= r + ROW_W'(1);
              end else if (r == '0) begin
                c <= c + COL_W'(1);
              end else begin
                r <= r - ROW_W'(1);
                c <= c + COL_W'(1);
              end
            end else begin
              if (at_last_row) begin
                c <= c + COL_W'(1);
              end else if (c == '0) begin
                r <= r + ROW_W'(1);
              end else begin
                r <= r + ROW_W'(1);
                c <= c - COL_W'(1);
              end
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/zigzag_diagonal_reorder.sv =====
// Loads a row_count x col_count matrix, one element beat per cycle in row-major
// order, into a 64-entry element memory, then plays it back in diagonal zigzag
// order with the final beat marked by out_last. Playback begins once the last
// element is taken, with reads issued whenever the read stage can take them;
// the first beat passes the walker state register, the RAM read register and
// the output register. Playback then moves one element per cycle through the
// memory's single read port while out_ready allows; out_ready stalls hold it.
// elem_ready is low during playback; the next matrix may start loading as soon
// as the last read is issued, while its results still drain. Counts of zero act
// as 1 and counts above 8 act as 8.
`include "zigzag_diagonal_reorder_macros.svh"

module zigzag_diagonal_reorder
  import zdr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     elem_valid,
  output logic                     elem_ready,
  input  logic signed [DATA_W-1:0] elem_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  logic [CFG_W-1:0]   row_count;
  logic [CFG_W-1:0]   col_count;
  logic [CNT_W-1:0]   load_count;
  logic [CNT_W-1:0]   load_count_next;
  logic [CNT_W-1:0]   rows;
  logic [CNT_W-1:0]   cols;
  logic [2*CNT_W-1:0] total_wide;
  logic [CNT_W-1:0]   total;
  logic               elem_accept;
  logic               start;
  logic               busy;
  logic               wr_en;
  rd_req_t            rd_req;
  logic               req_ok;
  logic               move;
  logic               rd_valid;
  logic               rd_last;
  logic [DATA_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rows            = clamp_dim(row_count, MAX_ROWS);
    cols            = clamp_dim(col_count, MAX_COLS);
    total_wide      = (2*CNT_W)'(rows) * (2*CNT_W)'(cols);
    total           = total_wide[CNT_W-1:0];
    elem_ready      = ~busy;
    elem_accept     = elem_valid && elem_ready;
    load_count_next = load_count + CNT_W'(1);
    start           = elem_accept && (load_count_next >= total);
    wr_en           = elem_accept && (int'(load_count) < STORE_DEPTH);
    move            = rd_valid && (!out_valid || out_ready);
    req_ok          = !rd_valid || move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (elem_accept) begin
      load_count <= start ? '0 : load_count_next;
    end
  end

  zdr_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (elem_value),
    .re    (rd_req.en),
    .raddr (rd_req.addr),
    .rdata (rd_data)
  );

  zdr_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_rows  (rows),
    .start_cols  (cols),
    .start_total (total),
    .req_ok      (req_ok),
    .busy        (busy),
    .req         (rd_req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_req.en) begin
        rd_valid <= 1'b1;
        rd_last  <= rd_req.last;
      end else if (move) begin
        rd_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
        out_value <= rd_data;
        out_last  <= rd_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ZDR_ASSERT_NXT(a_start_enters_playback, start, busy)
  `ZDR_ASSERT_IMP(a_playback_load_cleared, busy, load_count == '0)
  `ZDR_ASSERT_IMP(a_no_read_during_load, rd_req.en, !elem_accept)
  `ZDR_ASSERT_NXT(a_read_stage_holds, rd_valid && !move, rd_valid && $stable(rd_last))

endmodule

// ===== bench/zigzag_diagonal_reorder_test.sv =====
module zigzag_diagonal_reorder_test
  import zdr_pkg::*;
();

  localparam int LIMIT   = 300000;
  localparam int HOLDOFF = 8;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } zz_beat_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     elem_valid = 1'b0;
  logic                     elem_ready;
  logic signed [DATA_W-1:0] elem_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  logic signed [DATA_W-1:0] elem_pend_q[$];
  zz_beat_t                 walk_q[$];
  logic signed [DATA_W-1:0] elem_mem[STORE_DEPTH];
  logic [CFG_W-1:0]         rows_cfg = DIM_RESET;
  logic [CFG_W-1:0]         cols_cfg = DIM_RESET;
  int                       fill_count = 0;
  int                       send_idle_pct = 31;
  int                       recv_idle_pct = 85;
  int                       err_count = 0;
  int                       elems_taken = 0;
  int                       beats_seen = 0;
  int                       matrices = 0;
  int                       cycle_count = 0;

  zigzag_diagonal_reorder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .elem_valid(elem_valid),
    .elem_ready(elem_ready),
    .elem_value(elem_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_last  (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(7) == 0) begin
      if ($urandom_range(1) == 0) return '0;
      return CFG_W'($urandom_range(9, 15));
    end
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // Store one element; on the final one of the matrix, queue the diagonal walk.
  task automatic load_element(input logic signed [DATA_W-1:0] v);
    int rows, cols, total, r, c;
    zz_beat_t b;
    rows  = eff_dim(rows_cfg, MAX_ROWS);
    cols  = eff_dim(cols_cfg, MAX_COLS);
    total = rows * cols;
    if (fill_count < STORE_DEPTH) elem_mem[fill_count] = v;
    fill_count = (fill_count + 1) % 128;
    if (fill_count >= total) begin
      fill_count = 0;
      r = 0;
      c = 0;
      for (int k = 0; k < total; k++) begin
        b.value = elem_mem[r * cols + c];
        b.last  = (k == total - 1);
        walk_q = {walk_q, b};
        if (((r + c) % 2) == 0) begin
          if (c == cols - 1) r++;
          else if (r == 0) c++;
          else begin
            r--;
            c++;
          end
        end else begin
          if (r == rows - 1) c++;
          else if (c == 0) r++;
          else begin
            r++;
            c--;
          end
        end
      end
      matrices++;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want_v);
    err_count++;
    $display("mismatch on %s at beat %0d: got %h, want %h", field, beats_seen, got, want_v);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_cfg = val;
    else cols_cfg = val;
  endtask

  task automatic wait_taken();
    do @(negedge clk); while (elem_pend_q.size() != 0 || elem_valid);
  endtask

  task automatic wait_drained();
    while (walk_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] r_val, input logic [CFG_W-1:0] c_val);
    wait_taken();
    wait_drained();
    repeat (HOLDOFF) @(posedge clk);
    write_reg(REG_ROW_COUNT, r_val);
    write_reg(REG_COL_COUNT, c_val);
  endtask

  task automatic push_value(input logic signed [DATA_W-1:0] v);
    @(negedge clk);
    elem_pend_q = {elem_pend_q, v};
  endtask

  task automatic push_block(input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++) elem_pend_q = {elem_pend_q, rand_elem()};
  endtask

  // Present the next element once the current beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else if (!elem_valid || elem_ready) begin
      if (elem_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        elem_valid <= 1'b1;
        elem_value <= elem_pend_q.pop_front();
      end else begin
        elem_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    zz_beat_t want;
    if (!rst) begin
      if (elem_valid && elem_ready) begin
        load_element(elem_value);
        elems_taken++;
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (walk_q.size() == 0) begin
          report_mismatch("unexpected beat", out_value, '0);
        end else begin
          want = walk_q.pop_front();
          if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
          if (out_last !== want.last)
            report_mismatch("out_last", DATA_W'(out_last), DATA_W'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int mode_items, tot, n, settings;
    logic [CFG_W-1:0] r_sel, c_sel;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero counts act as one: single-element matrices.
    set_dims(4'd0, 4'd0);
    push_value(32'h8000_0000);
    push_value(32'h7fff_ffff);
    set_dims(4'd1, 4'd5);
    push_value(32'h0000_0000);
    push_value(32'hffff_ffff);
    push_value(32'h0000_0001);
    push_value(32'h7fff_fffe);
    push_value(32'h8000_0001);
    // Oversize row count acts as the maximum.
    set_dims(4'd15, 4'd1);
    push_block(8);
    set_dims(4'd2, 4'd3);
    push_block(6);
    // Shrink the matrix mid-load: next element passes the new total.
    set_dims(4'd3, 4'd3);
    push_block(4);
    set_dims(4'd2, 4'd2);
    push_block(1);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mode_items = 0;
      settings   = 0;
      while (mode_items < 128) begin
        if (settings == 0) begin
          r_sel = (mode == 0) ? 4'd8 : (mode == 1) ? 4'd1 : 4'd9;
          c_sel = (mode == 0) ? 4'd8 : (mode == 1) ? 4'd1 : 4'd0;
        end else begin
          r_sel = pick_dim();
          c_sel = pick_dim();
        end
        set_dims(r_sel, c_sel);
        tot = eff_dim(r_sel, MAX_ROWS) * eff_dim(c_sel, MAX_COLS);
        n   = $urandom_range(1, 2);
        for (int m = 0; m < n; m++) begin
          if (settings == 1 && m == 0 && tot > 1) begin
            // Hold the sender mid-matrix until every queued beat is out.
            push_block(tot / 2);
            wait_taken();
            wait_drained();
            push_block(tot - tot / 2);
          end else begin
            push_block(tot);
          end
          mode_items += tot;
        end
        if (settings > 0 && tot > 1 && $urandom_range(4) == 0) begin
          n = $urandom_range(1, tot - 1);
          push_block(n);
          mode_items += n;
        end
        settings++;
      end
    end

    wait_taken();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d elements loaded, %0d zigzag beats checked across %0d matrices",
             elems_taken, beats_seen, matrices);
    $display("sizes 1x1 to 8x8 with clamped counts, mid-load resizes and three stall mixes");
    if (err_count == 0 && walk_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
